// ----- sv/byte_range_lock_table_assert.svh -----
// Assertion macros shared by the lock table RTL.
`ifndef BYTE_RANGE_LOCK_TABLE_ASSERT_SVH
`define BYTE_RANGE_LOCK_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BLRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BLRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/blrt_pkg.sv -----
// Types and constants of the byte-range lock table.
`default_nettype none

package blrt_pkg;

  localparam int CHANNEL_W = 5;

  typedef enum logic [1:0] {
    REQ_LOCK    = 2'd0,
    REQ_UNLOCK  = 2'd1,
    REQ_CHECK   = 2'd2,
    REQ_RELEASE = 2'd3
  } blrt_req_t;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_BAD_CHANNEL = 3'd1,
    STAT_OVERLAP     = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_NOT_FOUND   = 3'd4
  } blrt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } blrt_state_t;

  // Per-entry compare flags from the match unit.
  typedef struct packed {
    logic conflict;
    logic exact;
    logic owned;
    logic free;
  } blrt_match_t;

endpackage

`default_nettype wire

// ----- sv/blrt_req_if.sv -----
// Request channel: valid/ready with one lock request per beat.
`default_nettype none

interface blrt_req_if #(
  parameter int FILE_ID_BITS = 8,
  parameter int RANGE_BITS   = 32
);
  import blrt_pkg::*;

  logic                    valid;
  logic                    ready;
  blrt_req_t               req_type;
  logic [CHANNEL_W-1:0]    channel;
  logic                    channel_open;
  logic [FILE_ID_BITS-1:0] file_id;
  logic [RANGE_BITS-1:0]   range_start;
  logic [RANGE_BITS-1:0]   range_end;

  modport source (
    output valid, req_type, channel, channel_open, file_id, range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, req_type, channel, channel_open, file_id, range_start, range_end,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/blrt_rsp_if.sv -----
// Result channel: valid/ready with one status per beat.
`default_nettype none

interface blrt_rsp_if;
  import blrt_pkg::*;

  logic         valid;
  logic         ready;
  blrt_status_t status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

`default_nettype wire

// ----- sv/byte_range_lock_table.sv -----
// Byte-range lock table: request sequencer, valid bits and entry store.
//
// in_req carries one request per beat: lock, unlock, check or release of all
// locks of a channel. out_rsp returns exactly one status beat per request.
// Both channels use valid/ready; a beat moves when both are high.
// Requests with a bad channel (or a closed one, for lock and check) are
// answered without touching the table: idle goes straight to the done state.
// All other requests scan the whole table, one entry per cycle through the
// entry store's single read port, then reach the done state; a granted lock
// first passes through the fill state (the fill write).
// One request is in flight at a time; in_req.ready is high only while idle,
// which also holds while a finished status waits in the output register.
// A new request is taken once the status has moved into the output register.
// If out_rsp stalls, the next finished status waits until the register frees.
// Reset (rst_n low at a clock edge) clears every valid bit, so the table is
// empty and usable in the cycle after reset; no clearing pass is needed.
`default_nettype none

module byte_range_lock_table #(
  parameter int LOCK_ENTRIES  = 64,
  parameter int CHANNEL_COUNT = 16,
  parameter int FILE_ID_BITS  = 8,
  parameter int RANGE_BITS    = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  blrt_req_if.sink   in_req,
  blrt_rsp_if.source out_rsp
);
  import blrt_pkg::*;

  `include "byte_range_lock_table_assert.svh"

  localparam int IDXW    = $clog2(LOCK_ENTRIES);
  localparam int CNTW    = $clog2(LOCK_ENTRIES + 1);
  localparam int ENTRY_W = CHANNEL_W + FILE_ID_BITS + 2 * RANGE_BITS;
  localparam logic [CNTW-1:0]      SCAN_END = CNTW'(LOCK_ENTRIES);
  localparam logic [CHANNEL_W-1:0] CH_MAX   = CHANNEL_W'(CHANNEL_COUNT);

  blrt_state_t state_r, state_nxt;

  // Latched request
  blrt_req_t               req_r;
  logic [CHANNEL_W-1:0]    ch_r;
  logic [FILE_ID_BITS-1:0] fid_r;
  logic [RANGE_BITS-1:0]   first_r;
  logic [RANGE_BITS-1:0]   last_r;
  logic                    load_req;

  // Scan control
  logic [CNTW-1:0] iss_r, iss_nxt;
  logic            cmp_vld_r, cmp_vld_nxt;
  logic [IDXW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic            conflict_r, conflict_nxt;
  logic            found_r, found_nxt;
  logic [IDXW-1:0] hit_r, hit_nxt;
  blrt_status_t    status_r, status_nxt;

  logic [LOCK_ENTRIES-1:0] valid_r, valid_nxt;

  logic                out_vld_r, out_vld_nxt;
  blrt_status_t        out_status_r, out_status_nxt;

  // Entry store
  logic               rd_en;
  logic [IDXW-1:0]    rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;

  logic [CHANNEL_W-1:0]    ent_ch;
  logic [FILE_ID_BITS-1:0] ent_fid;
  logic [RANGE_BITS-1:0]   ent_first;
  logic [RANGE_BITS-1:0]   ent_last;
  blrt_match_t             match;

  logic in_good;
  logic in_ready;

  assign wr_data = {ch_r, fid_r, first_r, last_r};
  assign {ent_ch, ent_fid, ent_first, ent_last} = rd_data;

  assign in_good = (in_req.channel != '0) && (in_req.channel <= CH_MAX);

  assign in_req.ready   = in_ready;
  assign out_rsp.valid  = out_vld_r;
  assign out_rsp.status = out_status_r;

  blrt_entry_ram #(
    .DEPTH (LOCK_ENTRIES),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (hit_r),
    .wr_data (wr_data)
  );

  blrt_match #(
    .FILE_ID_BITS (FILE_ID_BITS),
    .RANGE_BITS   (RANGE_BITS)
  ) u_match (
    .req_channel (ch_r),
    .req_file    (fid_r),
    .req_first   (first_r),
    .req_last    (last_r),
    .ent_valid   (valid_r[cmp_idx_r]),
    .ent_channel (ent_ch),
    .ent_file    (ent_fid),
    .ent_first   (ent_first),
    .ent_last    (ent_last),
    .match       (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    conflict_r   <= conflict_nxt;
    found_r      <= found_nxt;
    hit_r        <= hit_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    if (load_req) begin
      req_r   <= in_req.req_type;
      ch_r    <= in_req.channel;
      fid_r   <= in_req.file_id;
      first_r <= in_req.range_start;
      last_r  <= in_req.range_end;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    conflict_nxt   = conflict_r;
    found_nxt      = found_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    valid_nxt      = valid_r;
    out_status_nxt = out_status_r;
    out_vld_nxt    = out_vld_r && !out_rsp.ready;
    rd_en          = 1'b0;
    rd_addr        = iss_r[IDXW-1:0];
    wr_en          = 1'b0;
    in_ready       = 1'b0;
    load_req       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_req.valid) begin
          load_req     = 1'b1;
          iss_nxt      = '0;
          conflict_nxt = 1'b0;
          found_nxt    = 1'b0;
          hit_nxt      = '0;
          state_nxt    = ST_SCAN;
          unique case (in_req.req_type)
            REQ_LOCK: begin
              if (!in_good || !in_req.channel_open) begin
                status_nxt = STAT_BAD_CHANNEL;
                state_nxt  = ST_DONE;
              end
            end
            REQ_UNLOCK, REQ_RELEASE: begin
              if (!in_good) begin
                status_nxt = STAT_BAD_CHANNEL;
                state_nxt  = ST_DONE;
              end
            end
            REQ_CHECK: begin
              if (!in_good || !in_req.channel_open) begin
                status_nxt = STAT_OK;
                state_nxt  = ST_DONE;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is compared.
        if (iss_r < SCAN_END) begin
          rd_en       = 1'b1;
          iss_nxt     = iss_r + CNTW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IDXW-1:0];
        end
        if (cmp_vld_r) begin
          unique case (req_r)
            REQ_LOCK: begin
              if (match.conflict) begin
                conflict_nxt = 1'b1;
              end
              if (match.free && !found_r) begin
                found_nxt = 1'b1;
                hit_nxt   = cmp_idx_r;
              end
            end
            REQ_CHECK: begin
              if (match.conflict) begin
                conflict_nxt = 1'b1;
              end
            end
            REQ_UNLOCK: begin
              // Drop only the lowest exact match.
              if (match.exact && !found_r) begin
                found_nxt            = 1'b1;
                valid_nxt[cmp_idx_r] = 1'b0;
              end
            end
            REQ_RELEASE: begin
              if (match.owned) begin
                valid_nxt[cmp_idx_r] = 1'b0;
              end
            end
          endcase
        end else if (iss_r == SCAN_END) begin
          state_nxt = ST_DONE;
          unique case (req_r)
            REQ_LOCK: begin
              if (conflict_r) begin
                status_nxt = STAT_OVERLAP;
              end else if (found_r) begin
                state_nxt = ST_FILL;
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            REQ_CHECK:   status_nxt = conflict_r ? STAT_OVERLAP : STAT_OK;
            REQ_UNLOCK:  status_nxt = found_r ? STAT_OK : STAT_NOT_FOUND;
            REQ_RELEASE: status_nxt = STAT_OK;
          endcase
        end
      end

      ST_FILL: begin
        wr_en            = 1'b1;
        valid_nxt[hit_r] = 1'b1;
        status_nxt       = STAT_OK;
        state_nxt        = ST_DONE;
      end

      ST_DONE: begin
        // Hold the status until the output register frees.
        if (!out_vld_r || out_rsp.ready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
    endcase
  end

  `BLRT_ASSERT_NOW(a_fill_slot_free, state_r == ST_FILL, !valid_r[hit_r], "fill hits a live entry")
  `BLRT_ASSERT_NOW(a_cmp_after_read, cmp_vld_r, (state_r == ST_SCAN) && (iss_r != '0), "compare without read")
  `BLRT_ASSERT_NEXT(a_done_delivers, (state_r == ST_DONE) && (!out_vld_r || out_rsp.ready), out_vld_r && (out_status_r == $past(status_r)), "status not delivered")

endmodule

`default_nettype wire

// ----- sv/blrt_entry_ram.sv -----
// Entry store: one write port, one read port, registered read data.
`default_nettype none

module blrt_entry_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 77
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/blrt_match.sv -----
// Compare one stored lock entry against the pending request.
`default_nettype none

module blrt_match #(
  parameter int FILE_ID_BITS = 8,
  parameter int RANGE_BITS   = 32
) (
  input  wire logic [blrt_pkg::CHANNEL_W-1:0] req_channel,
  input  wire logic [FILE_ID_BITS-1:0]        req_file,
  input  wire logic [RANGE_BITS-1:0]          req_first,
  input  wire logic [RANGE_BITS-1:0]          req_last,
  input  wire logic                           ent_valid,
  input  wire logic [blrt_pkg::CHANNEL_W-1:0] ent_channel,
  input  wire logic [FILE_ID_BITS-1:0]        ent_file,
  input  wire logic [RANGE_BITS-1:0]          ent_first,
  input  wire logic [RANGE_BITS-1:0]          ent_last,
  output blrt_pkg::blrt_match_t               match
);
  import blrt_pkg::*;

  logic same_ch;
  logic disjoint;

  assign same_ch  = (ent_channel == req_channel);
  // Ranges are disjoint when one ends before the other starts.
  assign disjoint = (req_last < ent_first) || (req_first > ent_last);

  always_comb begin
    match.conflict = ent_valid && !same_ch && (ent_file == req_file) && !disjoint;
    match.exact    = ent_valid && same_ch && (ent_first == req_first) &&
                     (ent_last == req_last);
    match.owned    = ent_valid && same_ch;
    match.free     = !ent_valid;
  end

endmodule

`default_nettype wire

// ----- tb/blrt_lock_checker.sv -----
// Checker for the byte-range lock table: tracks the lock entries and compares each status beat.
module blrt_lock_checker #(
  parameter int LOCK_ENTRIES  = 64,
  parameter int CHANNEL_COUNT = 16,
  parameter int FILE_ID_BITS  = 8,
  parameter int RANGE_BITS    = 32
) (
  input  logic clk,
  input  logic rst_n,
  blrt_req_if  req_mon,
  blrt_rsp_if  rsp_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import blrt_pkg::*;

  logic                    lock_live  [LOCK_ENTRIES];
  logic [CHANNEL_W-1:0]    lock_owner [LOCK_ENTRIES];
  logic [FILE_ID_BITS-1:0] lock_file  [LOCK_ENTRIES];
  logic [RANGE_BITS-1:0]   lock_first [LOCK_ENTRIES];
  logic [RANGE_BITS-1:0]   lock_last  [LOCK_ENTRIES];

  blrt_status_t status_q[$];

  task automatic report_mismatch(string what);
    $display("ERROR %0t ns: %s", $time, what);
    fail_count++;
  endtask

  // Only live locks of other channels on the same file can conflict.
  function automatic logic foreign_overlap(logic [CHANNEL_W-1:0]    ch,
                                           logic [FILE_ID_BITS-1:0] fid,
                                           logic [RANGE_BITS-1:0]   lo,
                                           logic [RANGE_BITS-1:0]   hi);
    for (int i = 0; i < LOCK_ENTRIES; i++) begin
      if (lock_live[i] && lock_owner[i] != ch && lock_file[i] == fid &&
          !(hi < lock_first[i] || lo > lock_last[i])) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic blrt_status_t apply_request(blrt_req_t               kind,
                                                 logic [CHANNEL_W-1:0]    ch,
                                                 logic                    open,
                                                 logic [FILE_ID_BITS-1:0] fid,
                                                 logic [RANGE_BITS-1:0]   lo,
                                                 logic [RANGE_BITS-1:0]   hi);
    logic         good;
    blrt_status_t st;
    good = (int'(ch) >= 1) && (int'(ch) <= CHANNEL_COUNT);
    st   = STAT_OK;
    case (kind)
      REQ_LOCK: begin
        if (!good || !open) begin
          st = STAT_BAD_CHANNEL;
        end else if (foreign_overlap(ch, fid, lo, hi)) begin
          st = STAT_OVERLAP;
        end else begin
          st = STAT_FULL;
          for (int i = 0; i < LOCK_ENTRIES; i++) begin
            if (!lock_live[i]) begin
              lock_live[i]  = 1'b1;
              lock_owner[i] = ch;
              lock_file[i]  = fid;
              lock_first[i] = lo;
              lock_last[i]  = hi;
              st = STAT_OK;
              break;
            end
          end
        end
      end
      REQ_UNLOCK: begin
        if (!good) begin
          st = STAT_BAD_CHANNEL;
        end else begin
          st = STAT_NOT_FOUND;
          for (int i = 0; i < LOCK_ENTRIES; i++) begin
            if (lock_live[i] && lock_owner[i] == ch &&
                lock_first[i] == lo && lock_last[i] == hi) begin
              lock_live[i] = 1'b0;
              st = STAT_OK;
              break;
            end
          end
        end
      end
      REQ_CHECK: begin
        // A bad or closed channel reads as no conflict.
        if (good && open && foreign_overlap(ch, fid, lo, hi)) st = STAT_OVERLAP;
      end
      default: begin
        if (!good) begin
          st = STAT_BAD_CHANNEL;
        end else begin
          for (int i = 0; i < LOCK_ENTRIES; i++) begin
            if (lock_live[i] && lock_owner[i] == ch) lock_live[i] = 1'b0;
          end
        end
      end
    endcase
    return st;
  endfunction

  always @(posedge clk) begin
    blrt_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < LOCK_ENTRIES; i++) lock_live[i] = 1'b0;
      status_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("status beat %s with no request outstanding",
                                    rsp_mon.status.name()));
        end else begin
          want = status_q.pop_front();
          if (rsp_mon.status !== want) begin
            report_mismatch($sformatf("status %s, expected %s",
                                      rsp_mon.status.name(), want.name()));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        status_q.push_back(apply_request(req_mon.req_type, req_mon.channel,
                                         req_mon.channel_open, req_mon.file_id,
                                         req_mon.range_start, req_mon.range_end));
      end
    end
    pending = status_q.size();
  end

endmodule

// ----- tb/tb_byte_range_lock_table.sv -----
// Testbench top for the byte-range lock table: clock, reset, request and status traffic, verdict.
module tb_byte_range_lock_table;
  timeunit 1ns;
  timeprecision 1ps;
  import blrt_pkg::*;

  localparam int LOCK_ENTRIES  = 64;
  localparam int CHANNEL_COUNT = 16;
  localparam int FILE_ID_BITS  = 8;
  localparam int RANGE_BITS    = 32;
  localparam int ITEM_TARGET   = 1475;
  localparam int CYCLE_LIMIT   = 900000;
  localparam int CHOKE_CYCLES  = 400;
  localparam int SPAN_KEEP     = 32;

  typedef enum int {
    FILL_PHASE,
    MIX_PHASE,
    NOISE_PHASE
  } phase_kind_t;

  typedef struct {
    logic [CHANNEL_W-1:0]  ch;
    logic [RANGE_BITS-1:0] lo;
    logic [RANGE_BITS-1:0] hi;
  } held_span_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   total_sent;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   choke_len;
  logic choke_done;

  held_span_t recent_spans[$];

  blrt_req_if #(.FILE_ID_BITS(FILE_ID_BITS), .RANGE_BITS(RANGE_BITS)) in_req();
  blrt_rsp_if out_rsp();

  byte_range_lock_table #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .FILE_ID_BITS (FILE_ID_BITS),
    .RANGE_BITS   (RANGE_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  blrt_lock_checker #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .FILE_ID_BITS (FILE_ID_BITS),
    .RANGE_BITS   (RANGE_BITS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_mon   (in_req),
    .rsp_mon   (out_rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_byte_range_lock_table NOT OK");
      $finish;
    end
  end

  function automatic int idle_draw(int pct);
    return (int'($urandom_range(0, 99)) < pct) ? int'($urandom_range(0, 17)) : 0;
  endfunction

  function automatic int idle_share();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 30;
      default: return 100;
    endcase
  endfunction

  // Mostly small, clustered ranges so locks collide; some near the top, some inverted.
  function automatic void pick_span(output logic [RANGE_BITS-1:0] lo,
                                    output logic [RANGE_BITS-1:0] hi);
    logic [RANGE_BITS-1:0] swap;
    if ($urandom_range(0, 99) < 10) begin
      lo = RANGE_BITS'(32'hFFFF_FF00 + $urandom_range(0, 255));
      hi = lo + RANGE_BITS'($urandom_range(0, 40));
    end else begin
      lo = RANGE_BITS'($urandom_range(0, 63) * 32);
      hi = lo + RANGE_BITS'($urandom_range(0, 48));
    end
    if ($urandom_range(0, 99) < 10) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
  endfunction

  task automatic send_req(blrt_req_t               kind,
                          logic [CHANNEL_W-1:0]    ch,
                          logic                    open,
                          logic [FILE_ID_BITS-1:0] fid,
                          logic [RANGE_BITS-1:0]   lo,
                          logic [RANGE_BITS-1:0]   hi);
    int gap;
    gap = idle_draw(send_idle_pct);
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.req_type     = kind;
    in_req.channel      = ch;
    in_req.channel_open = open;
    in_req.file_id      = fid;
    in_req.range_start  = lo;
    in_req.range_end    = hi;
    in_req.valid        = 1'b1;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
    total_sent++;
    if (kind == REQ_LOCK) begin
      recent_spans.push_back('{ch, lo, hi});
      if (recent_spans.size() > SPAN_KEEP) void'(recent_spans.pop_front());
    end
  endtask

  task automatic run_phase(phase_kind_t shape, int count);
    logic [CHANNEL_W-1:0]    ch;
    logic                    open;
    logic [FILE_ID_BITS-1:0] fid;
    logic [RANGE_BITS-1:0]   lo;
    logic [RANGE_BITS-1:0]   hi;
    held_span_t              pick;
    int                      roll;
    for (int k = 0; k < count; k++) begin
      case (shape)
        FILL_PHASE: begin
          // One file per channel, so the table fills up and reports full.
          ch = CHANNEL_W'($urandom_range(1, CHANNEL_COUNT));
          pick_span(lo, hi);
          if ($urandom_range(0, 99) < 12) begin
            fid = FILE_ID_BITS'($urandom_range(1, CHANNEL_COUNT));
            send_req(REQ_CHECK, ch, 1'b1, fid, lo, hi);
          end else begin
            send_req(REQ_LOCK, ch, 1'b1, FILE_ID_BITS'(ch), lo, hi);
          end
        end
        MIX_PHASE: begin
          if ($urandom_range(0, 99) < 8) begin
            ch = ($urandom_range(0, 1) != 0) ? CHANNEL_W'(0)
                 : CHANNEL_W'($urandom_range(CHANNEL_COUNT + 1, 31));
          end else begin
            ch = CHANNEL_W'($urandom_range(1, 4));
          end
          open = ($urandom_range(0, 99) < 92);
          fid  = FILE_ID_BITS'($urandom_range(0, 3));
          pick_span(lo, hi);
          roll = $urandom_range(0, 99);
          if (roll < 38) begin
            send_req(REQ_LOCK, ch, open, fid, lo, hi);
          end else if (roll < 62) begin
            if (recent_spans.size() > 0 && $urandom_range(0, 99) < 75) begin
              pick = recent_spans[$urandom_range(0, recent_spans.size() - 1)];
              send_req(REQ_UNLOCK, pick.ch, open, fid, pick.lo, pick.hi);
            end else begin
              send_req(REQ_UNLOCK, ch, open, fid, lo, hi);
            end
          end else if (roll < 88) begin
            send_req(REQ_CHECK, ch, open, fid, lo, hi);
          end else begin
            send_req(REQ_RELEASE, ch, open, fid, lo, hi);
          end
        end
        default: begin
          send_req(blrt_req_t'(2'($urandom_range(0, 3))), CHANNEL_W'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), FILE_ID_BITS'($urandom),
                   RANGE_BITS'($urandom), RANGE_BITS'($urandom));
        end
      endcase
    end
    // Drain the table after a fill so later phases see free entries.
    if (shape == FILL_PHASE) begin
      for (int c = 1; c <= CHANNEL_COUNT; c++) begin
        send_req(REQ_RELEASE, CHANNEL_W'(c), 1'($urandom_range(0, 1)), '0, '0, '0);
      end
    end
  endtask

  // Status sink: random stalls, plus one long hold-off to back up the request side.
  initial begin : status_sink
    int hold;
    out_rsp.ready = 1'b0;
    choke_done    = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (choke_len > 0 && !choke_done) begin
        out_rsp.ready = 1'b0;
        repeat (choke_len) @(negedge clk);
        choke_done = 1'b1;
      end
      hold = idle_draw(recv_idle_pct);
      if (hold > 0) begin
        out_rsp.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_rsp.ready = 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      @(negedge clk);
    end
  end

  initial begin : request_source
    phase_kind_t shape;
    int          phase_no;
    int          roll;
    rst_n               = 1'b0;
    in_req.valid        = 1'b0;
    in_req.req_type     = REQ_LOCK;
    in_req.channel      = '0;
    in_req.channel_open = 1'b0;
    in_req.file_id      = '0;
    in_req.range_start  = '0;
    in_req.range_end    = '0;
    send_idle_pct       = 30;
    recv_idle_pct       = 30;
    choke_len           = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Whole-space lock, conflicts against it from another channel, a same-channel check.
    send_req(REQ_LOCK,    5'd1,  1'b1, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF);
    send_req(REQ_LOCK,    5'd2,  1'b1, 8'd0,   32'h8000_0000, 32'h8000_0000);
    send_req(REQ_CHECK,   5'd2,  1'b1, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_CHECK,   5'd1,  1'b1, 8'd0,   32'd5,         32'd5);
    // Same-channel overlap is allowed; other files never conflict.
    send_req(REQ_LOCK,    5'd1,  1'b1, 8'd0,   32'd10,        32'd20);
    send_req(REQ_LOCK,    5'd16, 1'b1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Bad and closed channels.
    send_req(REQ_LOCK,    5'd0,  1'b1, 8'd0,   32'd0,         32'd1);
    send_req(REQ_LOCK,    5'd17, 1'b1, 8'd0,   32'd0,         32'd1);
    send_req(REQ_LOCK,    5'd31, 1'b1, 8'd0,   32'd0,         32'd1);
    send_req(REQ_LOCK,    5'd5,  1'b0, 8'd0,   32'd0,         32'd1);
    send_req(REQ_CHECK,   5'd0,  1'b1, 8'd0,   32'd0,         32'd1);
    send_req(REQ_CHECK,   5'd2,  1'b0, 8'd0,   32'd0,         32'd1);
    // Exact-match unlock, repeat miss, bad channel.
    send_req(REQ_UNLOCK,  5'd1,  1'b1, 8'd0,   32'd10,        32'd20);
    send_req(REQ_UNLOCK,  5'd1,  1'b1, 8'd0,   32'd10,        32'd20);
    send_req(REQ_UNLOCK,  5'd0,  1'b1, 8'd0,   32'd10,        32'd20);
    // Inverted range is stored and compared as is.
    send_req(REQ_LOCK,    5'd3,  1'b1, 8'd7,   32'd100,       32'd50);
    send_req(REQ_CHECK,   5'd4,  1'b1, 8'd7,   32'd60,        32'd60);
    send_req(REQ_CHECK,   5'd4,  1'b1, 8'd7,   32'd40,        32'd200);
    // Release: owner, bad channel, channel with nothing held.
    send_req(REQ_RELEASE, 5'd1,  1'b1, 8'd0,   32'd0,         32'd0);
    send_req(REQ_RELEASE, 5'd31, 1'b1, 8'd0,   32'd0,         32'd0);
    send_req(REQ_RELEASE, 5'd9,  1'b0, 8'd0,   32'd0,         32'd0);
    send_req(REQ_LOCK,    5'd2,  1'b1, 8'd0,   32'h8000_0000, 32'h8000_0000);
    send_req(REQ_UNLOCK,  5'd3,  1'b0, 8'd99,  32'd100,       32'd50);
    send_req(REQ_RELEASE, 5'd16, 1'b0, 8'd0,   32'd0,         32'd0);

    phase_no = 0;
    while (total_sent < ITEM_TARGET) begin
      if (phase_no == 0) begin
        shape = FILL_PHASE;
      end else if (phase_no == 1) begin
        shape = MIX_PHASE;
      end else begin
        roll  = $urandom_range(0, 99);
        shape = (roll < 55) ? MIX_PHASE : (roll < 75) ? FILL_PHASE : NOISE_PHASE;
      end
      send_idle_pct = idle_share();
      recv_idle_pct = idle_share();
      if (phase_no == 1) choke_len = CHOKE_CYCLES;
      run_phase(shape, (shape == FILL_PHASE) ? 74 : int'($urandom_range(30, 70)));
      phase_no++;
    end
    in_req.valid = 1'b0;

    wait (pending == 0);
    repeat (LOCK_ENTRIES + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_byte_range_lock_table OK");
    end else begin
      $display("tb_byte_range_lock_table NOT OK");
    end
    $finish;
  end

endmodule
